FILE: hdl/wav_riff_header_parser_top_defines.svh
// Assertion helpers for the WAV header parser.
`ifndef WAV_RIFF_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define WRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wrp assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define WRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wrp assertion failed");

`endif

FILE: hdl/wrp_pkg.sv
`default_nettype none

package wrp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DESC,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_e;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY = 32'd16;

  localparam logic [3:0] IDX_TAG_END  = 4'd3;
  localparam logic [3:0] IDX_SIZE_END = 4'd7;
  localparam logic [3:0] IDX_DESC_END = 4'd11;
  localparam logic [3:0] IDX_FMT_END  = 4'd15;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_WAV = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] fmt_chunk_size;
    logic [31:0] data_size;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/wrp_core.sv
`default_nettype none

module wrp_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_in_i,
  input  wire logic            first_byte_i,
  input  wire logic            end_of_stream_i,
  output logic                 emit_o,
  output wrp_pkg::result_t     result_o
);
  import wrp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] tag_q, tag_d;
  logic [32:0] skip_q, skip_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] fsize_q, fsize_d;
  logic        seen_q, seen_d;

  logic        emit;
  logic [1:0]  status;
  logic [31:0] dsize;
  logic [31:0] size;
  logic [32:0] skip_dec;

  always_comb begin
    // restart clears everything and treats this byte as byte 0
    phase_d = first_byte_i ? PH_DESC : phase_q;
    idx_d   = first_byte_i ? '0 : idx_q;
    shift_d = first_byte_i ? '0 : shift_q;
    tag_d   = first_byte_i ? '0 : tag_q;
    skip_d  = first_byte_i ? '0 : skip_q;
    fmt_d   = first_byte_i ? '0 : fmt_q;
    chan_d  = first_byte_i ? '0 : chan_q;
    rate_d  = first_byte_i ? '0 : rate_q;
    brate_d = first_byte_i ? '0 : brate_q;
    align_d = first_byte_i ? '0 : align_q;
    bits_d  = first_byte_i ? '0 : bits_q;
    fsize_d = first_byte_i ? '0 : fsize_q;
    seen_d  = first_byte_i ? 1'b0 : seen_q;
    emit    = 1'b0;
    status  = ST_OK;
    dsize   = '0;
    size    = '0;
    skip_dec = '0;

    if (phase_d != PH_IDLE && phase_d != PH_DONE) begin
      shift_d = {byte_in_i, shift_d[31:8]};
      size    = shift_d;
      unique case (phase_d)
        PH_DESC: begin
          if (idx_d == IDX_TAG_END) tag_d = shift_d;
          if (idx_d == IDX_DESC_END) begin
            if (tag_d != TAG_RIFF || shift_d != TAG_WAVE) begin
              emit   = 1'b1;
              status = ST_NOT_WAV;
            end else begin
              phase_d = PH_CHDR;
              idx_d   = '0;
              if (end_of_stream_i) begin
                emit   = 1'b1;
                status = ST_MISSING;
              end
            end
          end else begin
            idx_d = idx_d + 4'd1;
            if (end_of_stream_i) begin
              emit   = 1'b1;
              status = ST_NOT_WAV;
            end
          end
        end
        PH_CHDR: begin
          if (idx_d == IDX_TAG_END) tag_d = shift_d;
          if (idx_d == IDX_SIZE_END) begin
            idx_d = '0;
            if (tag_d == TAG_DATA) begin
              emit   = 1'b1;
              status = seen_d ? ST_OK : ST_MISSING;
              dsize  = size;
            end else if (tag_d == TAG_FMT) begin
              fsize_d = size;
              skip_d  = ((size > FMT_BODY) ? {1'b0, size - FMT_BODY} : 33'd0)
                        + {32'd0, size[0]};
              phase_d = PH_FMT;
            end else begin
              skip_d  = {1'b0, size} + {32'd0, size[0]};
              phase_d = (skip_d != '0) ? PH_SKIP : PH_CHDR;
            end
          end else begin
            idx_d = idx_d + 4'd1;
          end
        end
        PH_FMT: begin
          case (idx_d)
            4'd0, 4'd1:               fmt_d[{idx_d[0], 3'b000} +: 8] = byte_in_i;
            4'd2, 4'd3:               chan_d[{idx_d[0], 3'b000} +: 8] = byte_in_i;
            4'd4, 4'd5, 4'd6, 4'd7:   rate_d[{idx_d[1:0], 3'b000} +: 8] = byte_in_i;
            4'd8, 4'd9, 4'd10, 4'd11: brate_d[{idx_d[1:0], 3'b000} +: 8] = byte_in_i;
            4'd12, 4'd13:             align_d[{idx_d[0], 3'b000} +: 8] = byte_in_i;
            default:                  bits_d[{idx_d[0], 3'b000} +: 8] = byte_in_i;
          endcase
          if (idx_d == IDX_FMT_END) begin
            seen_d  = 1'b1;
            idx_d   = '0;
            phase_d = (skip_d != '0) ? PH_SKIP : PH_CHDR;
          end else begin
            idx_d = idx_d + 4'd1;
          end
        end
        PH_SKIP: begin
          skip_dec = skip_d - 33'd1;
          if (skip_d != '0) skip_d = skip_dec;
          if (skip_d == '0) begin
            phase_d = PH_CHDR;
            idx_d   = '0;
          end
        end
        default: ;
      endcase
      // stream ran out before the data header
      if (!emit && end_of_stream_i) begin
        emit   = 1'b1;
        status = ST_MISSING;
      end
      if (emit) phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      shift_q <= '0;
      tag_q   <= '0;
      skip_q  <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      brate_q <= '0;
      align_q <= '0;
      bits_q  <= '0;
      fsize_q <= '0;
      seen_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      tag_q   <= tag_d;
      skip_q  <= skip_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      brate_q <= brate_d;
      align_q <= align_d;
      bits_q  <= bits_d;
      fsize_q <= fsize_d;
      seen_q  <= seen_d;
    end
  end

  assign emit_o = emit;

  always_comb begin
    result_o.status          = status;
    result_o.audio_format    = fmt_d;
    result_o.num_channels    = chan_d;
    result_o.sample_rate     = rate_d;
    result_o.byte_rate       = brate_d;
    result_o.block_align     = align_d;
    result_o.bits_per_sample = bits_d;
    result_o.fmt_chunk_size  = fsize_d;
    result_o.data_size       = dsize;
  end

endmodule

`default_nettype wire

FILE: hdl/wav_riff_header_parser_top.sv
// WAV RIFF header parser.
// Input channel (in_valid_i / in_ready_o): one file byte per word, with
// first_byte_i marking byte 0 of a file (restarts the parse at any time)
// and end_of_stream_i marking the last byte available.
// Output channel (out_valid_o / out_ready_i): at most one result word per
// file: status plus the fmt fields and the data chunk size. It is produced
// when the data chunk header completes, when the descriptor is bad, or
// when the stream ends first. Bytes after that are dropped until the next
// first byte.
// Throughput: one byte per cycle while in_ready_o is high.
// The result word is registered: it is on the output in the cycle after
// the byte that ends the parse is accepted.
// A finished result sits in the output register; while it waits and
// out_ready_i is low, in_ready_o drops, so the walker halts. When the
// result is taken in the same cycle, a new byte is still accepted.
// Reset: the parser goes idle with all stored fields zero and ignores
// bytes until one arrives with first_byte_i set; the output is empty.
`default_nettype none
`include "wav_riff_header_parser_top_defines.svh"

module wav_riff_header_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        first_byte_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      audio_format_o,
  output logic [15:0]      num_channels_o,
  output logic [31:0]      sample_rate_o,
  output logic [31:0]      byte_rate_o,
  output logic [15:0]      block_align_o,
  output logic [15:0]      bits_per_sample_o,
  output logic [31:0]      fmt_chunk_size_o,
  output logic [31:0]      data_size_o
);
  import wrp_pkg::*;

  logic    accept;
  logic    emit;
  result_t res;
  result_t res_q;
  logic    out_valid_q;

  // a held result only blocks input while the receiver is stalled
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  wrp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .byte_in_i       (byte_in_i),
    .first_byte_i    (first_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .emit_o          (emit),
    .result_o        (res)
  );

  // output register: valid is control, result word is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.status;
  assign audio_format_o    = res_q.audio_format;
  assign num_channels_o    = res_q.num_channels;
  assign sample_rate_o     = res_q.sample_rate;
  assign byte_rate_o       = res_q.byte_rate;
  assign block_align_o     = res_q.block_align;
  assign bits_per_sample_o = res_q.bits_per_sample;
  assign fmt_chunk_size_o  = res_q.fmt_chunk_size;
  assign data_size_o       = res_q.data_size;

  // stalled result must hold off new bytes
  `WRP_ASSERT_NOW(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)
  // an emitted result shows up the next cycle
  `WRP_ASSERT_NEXT(a_emit_shows, accept && emit, out_valid_o)
  // status never takes the unused code
  `WRP_ASSERT_NOW(a_status_legal, out_valid_o, status_o != 2'd3)
  // only an ok or missing-chunk result carries a data size
  `WRP_ASSERT_NOW(a_dsize_status, out_valid_o && data_size_o != 32'd0,
                  status_o != ST_NOT_WAV)

endmodule

`default_nettype wire

FILE: tb/tb_wav_riff_header_parser_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the WAV RIFF header parser.
// A byte-level model runs on every accepted input word and queues the header
// word it predicts; the monitor pops and compares on every output handshake.
module tb_wav_riff_header_parser_top;
  import wrp_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int RST_CYCLES = 5;
  localparam int CYC_LIMIT  = 400000;
  localparam int GAP_MAX    = 6;
  localparam int RAND_BYTES = 690;
  localparam int RAND_FILES = 10;      // keep going until enough headers came
  localparam int LONG_HOLD  = 120;
  localparam int TAIL_WAIT  = 8;       // result shows in the cycle after the byte

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        first_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [15:0] audio_format;
  logic [15:0] num_channels;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [31:0] fmt_chunk_size;
  logic [31:0] data_size;

  wav_riff_header_parser_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .byte_in_i        (byte_in),
    .first_byte_i     (first_byte),
    .end_of_stream_i  (end_of_stream),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .audio_format_o   (audio_format),
    .num_channels_o   (num_channels),
    .sample_rate_o    (sample_rate),
    .byte_rate_o      (byte_rate),
    .block_align_o    (block_align),
    .bits_per_sample_o(bits_per_sample),
    .fmt_chunk_size_o (fmt_chunk_size),
    .data_size_o      (data_size)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  result_t     pending_headers[$];  // predicted header words, oldest first
  logic [7:0]  wav_bytes[$];        // file image under construction
  int          err_cnt    = 0;
  int          bytes_sent = 0;
  int          files_done = 0;      // headers predicted so far
  int          gap_left   = 0;      // sender idle cycles before next word
  bit          vld_held   = 0;      // in_valid left high for a back-to-back word
  bit          no_idle    = 0;      // both sides run flat out while set
  int          hold_req   = 0;      // long receiver hold-off, taken by monitor
  int          stall_cnt  = 0;
  int          cyc_cnt    = 0;

  // ---------------------------------------------------------------------------
  // Parser model: own copy of the walker state
  // ---------------------------------------------------------------------------
  phase_e       m_phase = PH_IDLE;
  logic [3:0]   m_idx   = '0;
  logic [31:0]  m_shift = '0;   // last four bytes, little-endian
  logic [31:0]  m_tag   = '0;
  logic [32:0]  m_skip  = '0;   // 33 bits: a 4 GiB chunk plus its pad byte
  logic [127:0] m_body  = '0;   // the 16 fmt field bytes as received
  logic [31:0]  m_fsize = '0;
  logic         m_fmt_ok = 1'b0;

  task automatic parse_byte(input logic [7:0] b, input logic is_first,
                            input logic is_last);
    logic [3:0]  i;
    logic [31:0] sz;
    bit          done;
    logic [1:0]  st;
    logic [31:0] dsz;
    result_t     hdr;
    // first byte restarts from any phase, fmt values wiped
    if (is_first) begin
      m_phase  = PH_DESC;
      m_idx    = '0;
      m_shift  = '0;
      m_tag    = '0;
      m_skip   = '0;
      m_body   = '0;
      m_fsize  = '0;
      m_fmt_ok = 1'b0;
    end
    // idle before a first byte, or finished: word is dropped
    if (m_phase == PH_IDLE || m_phase == PH_DONE) return;
    m_shift = {b, m_shift[31:8]};
    i    = m_idx;
    done = 0;
    st   = ST_MISSING;
    dsz  = '0;
    case (m_phase)
      PH_DESC: begin
        if (i == IDX_TAG_END) m_tag = m_shift;
        if (i == IDX_DESC_END) begin
          if (m_tag != TAG_RIFF || m_shift != TAG_WAVE) begin
            done = 1;
            st   = ST_NOT_WAV;
          end else begin
            m_phase = PH_CHDR;
            m_idx   = '0;
          end
        end else begin
          m_idx = i + 4'd1;
          // stream ends inside the descriptor
          if (is_last) begin
            done = 1;
            st   = ST_NOT_WAV;
          end
        end
      end
      PH_CHDR: begin
        if (i == IDX_TAG_END) m_tag = m_shift;
        if (i == IDX_SIZE_END) begin
          sz    = m_shift;
          m_idx = '0;
          if (m_tag == TAG_DATA) begin
            // no pad skip after data, odd size or not
            done = 1;
            st   = m_fmt_ok ? ST_OK : ST_MISSING;
            dsz  = sz;
          end else if (m_tag == TAG_FMT) begin
            // short fmt still reads 16 field bytes
            m_fsize = sz;
            m_skip  = (sz > FMT_BODY ? {1'b0, sz - FMT_BODY} : 33'd0) + {32'd0, sz[0]};
            m_phase = PH_FMT;
          end else begin
            m_skip  = {1'b0, sz} + {32'd0, sz[0]};
            m_phase = (m_skip != 0) ? PH_SKIP : PH_CHDR;
          end
        end else begin
          m_idx = i + 4'd1;
        end
      end
      PH_FMT: begin
        m_body[i*8 +: 8] = b;
        if (i == IDX_FMT_END) begin
          m_fmt_ok = 1'b1;
          m_idx    = '0;
          m_phase  = (m_skip != 0) ? PH_SKIP : PH_CHDR;
        end else begin
          m_idx = i + 4'd1;
        end
      end
      default: begin
        if (m_skip != 0) m_skip = m_skip - 33'd1;
        if (m_skip == 0) begin
          m_phase = PH_CHDR;
          m_idx   = '0;
        end
      end
    endcase
    if (!done && is_last) begin
      done = 1;
      st   = ST_MISSING;
    end
    if (done) begin
      hdr.status          = st;
      hdr.audio_format    = m_body[15:0];
      hdr.num_channels    = m_body[31:16];
      hdr.sample_rate     = m_body[63:32];
      hdr.byte_rate       = m_body[95:64];
      hdr.block_align     = m_body[111:96];
      hdr.bits_per_sample = m_body[127:112];
      hdr.fmt_chunk_size  = m_fsize;
      hdr.data_size       = dsz;
      pending_headers.push_back(hdr);
      m_phase = PH_DONE;
      files_done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    while (cyc_cnt < CYC_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("** wav_riff_header_parser_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: one word per call. Valid stays high across a zero gap so it is
  // never dropped and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_first,
                           input logic is_last);
    repeat (gap_left) @(posedge clk);
    byte_in       <= b;
    first_byte    <= is_first;
    end_of_stream <= is_last;
    if (!vld_held) in_valid <= 1'b1;
    vld_held = 1;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, is_first, is_last);
    bytes_sent++;
    gap_left = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap_left != 0) begin
      in_valid <= 1'b0;
      vld_held = 0;
    end
  endtask

  task automatic pause_input();
    if (vld_held) begin
      in_valid <= 1'b0;
      vld_held = 0;
    end
    gap_left = 0;
  endtask

  // sender holds still until every predicted header has been taken
  task automatic wait_drained();
    pause_input();
    do @(posedge clk); while (pending_headers.size() != 0);
  endtask

  // sends the file image, first byte flagged if asked, last byte flagged if asked
  task automatic send_file(input bit with_first, input bit with_end);
    int n;
    n = wav_bytes.size();
    for (int k = 0; k < n; k++)
      send_byte(wav_bytes[k], with_first && k == 0, with_end && k == n - 1);
    wav_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: compares on handshake, then draws the next ready stall.
  // A long hold-off request is counted down here.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_header();
    result_t exp_h;
    if (pending_headers.size() == 0) begin
      $error("header word with nothing pending: status %0d data_size %0h",
             status, data_size);
      err_cnt++;
      return;
    end
    exp_h = pending_headers.pop_front();
    check_field("status",          32'(exp_h.status),          32'(status));
    check_field("audio_format",    32'(exp_h.audio_format),    32'(audio_format));
    check_field("num_channels",    32'(exp_h.num_channels),    32'(num_channels));
    check_field("sample_rate",     exp_h.sample_rate,          sample_rate);
    check_field("byte_rate",       exp_h.byte_rate,            byte_rate);
    check_field("block_align",     32'(exp_h.block_align),     32'(block_align));
    check_field("bits_per_sample", 32'(exp_h.bits_per_sample), 32'(bits_per_sample));
    check_field("fmt_chunk_size",  exp_h.fmt_chunk_size,       fmt_chunk_size);
    check_field("data_size",       exp_h.data_size,            data_size);
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_header();
      if (hold_req != 0) begin
        stall_cnt = hold_req;
        hold_req  = 0;
      end else if (out_valid && out_ready) begin
        stall_cnt = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (stall_cnt != 0) begin
        out_ready <= 1'b0;
        stall_cnt--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // File image builders
  // ---------------------------------------------------------------------------
  task automatic push_le32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) wav_bytes.push_back(v[8*k +: 8]);
  endtask

  task automatic push_desc();
    push_le32(TAG_RIFF);
    push_le32($urandom);  // file size, not checked by the block
    push_le32(TAG_WAVE);
  endtask

  // fill < 0: random field bytes, else every field byte equals fill
  task automatic push_fmt(input logic [31:0] sz, input int fill);
    longint extra;
    push_le32(TAG_FMT);
    push_le32(sz);
    for (int k = 0; k < 16; k++)
      wav_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    extra = (sz > FMT_BODY ? longint'(sz - FMT_BODY) : 0) + sz[0];
    repeat (extra) wav_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [31:0] junk_tag();
    logic [31:0] t;
    t = $urandom;
    if (t == TAG_FMT || t == TAG_DATA) t = ~t;
    return t;
  endfunction

  task automatic push_junk(input logic [31:0] sz);
    push_le32(junk_tag());
    push_le32(sz);
    repeat (sz + sz[0]) wav_bytes.push_back(8'($urandom));
  endtask

  task automatic push_data(input logic [31:0] sz);
    push_le32(TAG_DATA);
    push_le32(sz);
  endtask

  function automatic logic [31:0] pick_fmt_size();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 15);
      1, 2:    return $urandom_range(17, 40);
      default: return FMT_BODY;
    endcase
  endfunction

  function automatic logic [31:0] pick_junk_size();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
  endfunction

  // descriptor, optional junk, data header first if asked, fmt, optional junk, data header
  task automatic build_good(input bit data_first);
    push_desc();
    repeat ($urandom_range(0, 2)) push_junk(pick_junk_size());
    if (data_first) push_data($urandom);
    push_fmt(pick_fmt_size(), -1);
    repeat ($urandom_range(0, 1)) push_junk(pick_junk_size());
    push_data($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // bytes ahead of any first byte are dropped; bytes after the end are dropped
  task automatic test_idle_bytes();
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h52, 1'b0, 1'b0);
    push_desc();
    push_fmt(FMT_BODY, 8'hFF);
    push_data(32'hFFFF_FFFF);
    repeat (3) wav_bytes.push_back(8'($urandom));
    send_file(1, 0);
    send_byte(8'hAA, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_descriptor();
    // "RIFX"
    push_desc();
    wav_bytes[3] = 8'h58;
    send_file(1, 0);
    // bad WAVE tag
    push_desc();
    wav_bytes[11] = wav_bytes[11] ^ 8'h01;
    push_fmt(FMT_BODY, -1);
    send_file(1, 0);
    // good, all-zero fields, zero data size
    push_desc();
    push_fmt(FMT_BODY, 0);
    push_data(32'd0);
    send_file(1, 1);
    wait_drained();
  endtask

  task automatic test_short_stream();
    // single byte that is both first and last
    send_byte(8'h52, 1'b1, 1'b1);
    // ends inside the descriptor
    push_desc();
    wav_bytes = wav_bytes[0:5];
    send_file(1, 1);
    // valid descriptor ending exactly on its last byte
    push_desc();
    send_file(1, 1);
    // ends inside a chunk header
    push_desc();
    push_le32(TAG_FMT);
    push_le32(FMT_BODY);
    wav_bytes = wav_bytes[0:16];
    send_file(1, 1);
    // ends inside the fmt fields
    push_desc();
    push_fmt(FMT_BODY, -1);
    wav_bytes = wav_bytes[0:25];
    send_file(1, 1);
    // ends inside a skipped chunk after fmt
    push_desc();
    push_fmt(FMT_BODY, -1);
    push_junk(32'd9);
    wav_bytes = wav_bytes[0:wav_bytes.size() - 3];
    send_file(1, 1);
    // 4 GiB chunk: skip counter needs its 33rd bit
    push_desc();
    push_le32(junk_tag());
    push_le32(32'hFFFF_FFFF);
    repeat (5) wav_bytes.push_back(8'($urandom));
    send_file(1, 1);
    // huge fmt trailer, cut a few bytes past the fields
    push_desc();
    push_le32(TAG_FMT);
    push_le32(32'hFFFF_FFFF);
    repeat (21) wav_bytes.push_back(8'($urandom));
    send_file(1, 1);
    wait_drained();
  endtask

  task automatic test_chunk_walk();
    // data header before fmt: missing, size still reported
    push_desc();
    push_data(32'h1234_5679);
    send_file(1, 0);
    // short fmt of size 0, zero-size junk, odd data size ends on the size byte
    push_desc();
    push_fmt(32'd0, -1);
    push_junk(32'd0);
    push_data(32'h0000_0007);
    send_file(1, 1);
    // odd short fmt skips its pad byte; odd junk chunk too
    push_desc();
    push_fmt(32'd15, -1);
    push_junk(32'd5);
    push_data($urandom);
    send_file(1, 0);
    // fmt with trailing bytes plus pad, then a second fmt
    push_desc();
    push_fmt(32'd17, -1);
    push_fmt(32'd20, -1);
    push_data(32'hFFFF_FFFF);
    send_file(1, 0);
    // fmt complete, then stream ends on a junk header
    push_desc();
    push_fmt(FMT_BODY, -1);
    push_le32(junk_tag());
    send_file(1, 1);
    wait_drained();
  endtask

  task automatic test_restart();
    // abandoned mid-fmt, then a full file restarts the parse
    push_desc();
    push_fmt(FMT_BODY, 8'hFF);
    wav_bytes = wav_bytes[0:27];
    send_file(1, 0);
    build_good(0);
    send_file(1, 0);
    // restart while finished and another while skipping
    build_good(0);
    send_file(1, 0);
    push_desc();
    push_junk(32'd30);
    wav_bytes = wav_bytes[0:30];
    send_file(1, 0);
    push_desc();
    push_data(32'd3);
    send_file(1, 0);
    wait_drained();
  endtask

  // receiver holds off while short bad files keep coming: the output word
  // sits in its register and the input backs up behind it
  task automatic test_backpressure();
    no_idle  = 1;
    hold_req = LONG_HOLD;
    repeat (6) begin
      push_desc();
      wav_bytes[0] = wav_bytes[0] ^ 8'h80;
      send_file(1, 0);
    end
    no_idle = 0;
    wait_drained();
  endtask

  task automatic test_random();
    int kind;
    int n;
    int bp;
    int start_bytes;
    int start_files;
    start_bytes = bytes_sent;
    start_files = files_done;
    while (bytes_sent - start_bytes < RAND_BYTES || files_done - start_files < RAND_FILES) begin
      kind    = $urandom_range(0, 19);
      no_idle = ($urandom_range(0, 7) == 0);
      case (kind)
        12: begin
          build_good(1);
          send_file(1, 1'($urandom_range(0, 1)));
        end
        13: begin
          push_desc();
          n = $urandom_range(0, 7);
          n = (n < 4) ? n : n + 4;
          bp = $urandom_range(0, 7);
          wav_bytes[n][bp] = ~wav_bytes[n][bp];
          push_junk(pick_junk_size());
          send_file(1, 1'($urandom_range(0, 1)));
        end
        14, 15, 16: begin
          // truncated; without an end marker the next first byte restarts
          build_good(0);
          n = $urandom_range(1, wav_bytes.size() - 1);
          wav_bytes = wav_bytes[0:n-1];
          send_file(1, kind != 16);
        end
        17, 18: begin
          // noise, with or without a first byte
          repeat ($urandom_range(1, 30)) wav_bytes.push_back(8'($urandom));
          send_file(kind == 17, 1'($urandom_range(0, 1)));
        end
        19: begin
          push_desc();
          push_le32(junk_tag());
          push_le32($urandom | 32'h8000_0000);
          repeat ($urandom_range(0, 10)) wav_bytes.push_back(8'($urandom));
          send_file(1, 1);
        end
        default: begin
          build_good(0);
          repeat ($urandom_range(0, 4)) wav_bytes.push_back(8'($urandom));
          send_file(1, 1'($urandom_range(0, 1)));
        end
      endcase
      // now and then let everything drain before the next file
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    no_idle = 0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    byte_in       = '0;
    first_byte    = 1'b0;
    end_of_stream = 1'b0;
    out_ready     = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_descriptor();
    test_short_stream();
    test_chunk_walk();
    test_restart();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_headers.size() != 0) begin
      $error("%0d header words never arrived", pending_headers.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** wav_riff_header_parser_top: PASSED **");
    end else begin
      $display("** wav_riff_header_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
